FILE: sv/mie_pkg.sv
// Shared types and constants for the modular inverse unit.
package mie_pkg;

	// Default operand width in bits.
	localparam int OPERAND_BITS_DEF = 31;

	// Width of the status field.
	localparam int STATUS_BITS = 2;

	// Result status codes.
	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK       = 2'd0,
		ST_NO_INV   = 2'd1,
		ST_ZERO_MOD = 2'd2
	} status_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_ALIGN,
		S_REDUCE,
		S_FINISH
	} ctrl_state_t;

	// Datapath operations issued by the controller.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_BEGIN,
		OP_ALIGN,
		OP_REDUCE,
		OP_SWAP,
		OP_FINISH
	} dp_op_t;

	// Status flags reported by the datapath.
	typedef struct packed {
		logic r1_zero;
		logic aligned;
		logic cnt_zero;
	} dp_flags_t;

endpackage

FILE: sv/mie_datapath.sv
// Datapath: remainder and coefficient registers with a shift-subtract divide step.
module mie_datapath
	import mie_pkg::*;
#(
	parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [OPERAND_BITS-1:0] in_value,
	input  logic [OPERAND_BITS-1:0] in_modulus,
	input  dp_op_t                  op,
	output dp_flags_t               flags,
	output logic [OPERAND_BITS-1:0] out_inverse,
	output logic [OPERAND_BITS-1:0] out_gcd,
	output status_t                 out_status
);

	localparam int W  = OPERAND_BITS;
	localparam int CW = $clog2(W + 1);

	// Remainder pair, coefficient magnitude pair and the original modulus.
	logic [W-1:0]  r0_q, r1_q, s0_q, s1_q, mod_q;
	// Shifted divisor and shifted coefficient for the current quotient.
	logic [W:0]    d_q, sh_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q;

	// Result registers.
	logic [W-1:0]  inv_q, gcd_q;
	status_t       status_q;

	logic [W:0]    d_half, sh_half, s_sum;
	logic          take;
	logic [W-1:0]  inv_red, inv_val;
	status_t       status_val;

	// One restoring step: halve the divisor and subtract where it fits.
	assign d_half  = d_q >> 1;
	assign sh_half = sh_q >> 1;
	assign take    = d_half <= {1'b0, r0_q};
	assign s_sum   = {1'b0, s0_q} + sh_half;

	// Status toward the controller.
	assign flags.r1_zero  = r1_q == '0;
	assign flags.aligned  = d_q > {1'b0, r0_q};
	assign flags.cnt_zero = cnt_q == '0;

	// Final normalization of the coefficient into 1..modulus.
	always_comb begin
		inv_red    = (s0_q == mod_q) ? '0 : s0_q;
		inv_val    = '0;
		status_val = ST_OK;
		if (mod_q == '0) begin
			status_val = ST_ZERO_MOD;
		end else if (r0_q != W'(1)) begin
			status_val = ST_NO_INV;
		end else if (neg_q) begin
			inv_val = mod_q - inv_red;
		end else begin
			inv_val = (inv_red == '0) ? mod_q : inv_red;
		end
	end

	// Register updates per operation.
	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD: begin
				r0_q  <= in_value;
				r1_q  <= in_modulus;
				mod_q <= in_modulus;
				s0_q  <= W'(1);
				s1_q  <= '0;
				neg_q <= 1'b0;
			end
			OP_BEGIN: begin
				d_q   <= {1'b0, r1_q};
				sh_q  <= {1'b0, s1_q};
				cnt_q <= '0;
			end
			OP_ALIGN: begin
				d_q   <= d_q << 1;
				sh_q  <= sh_q << 1;
				cnt_q <= cnt_q + CW'(1);
			end
			OP_REDUCE: begin
				d_q   <= d_half;
				sh_q  <= sh_half;
				cnt_q <= cnt_q - CW'(1);
				if (take) begin
					r0_q <= r0_q - d_half[W-1:0];
					s0_q <= s_sum[W-1:0];
				end
			end
			OP_SWAP: begin
				r0_q  <= r1_q;
				r1_q  <= r0_q;
				s0_q  <= s1_q;
				s1_q  <= s0_q;
				neg_q <= ~neg_q;
			end
			default: begin
			end
		endcase
	end

	// Result word register, cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q    <= '0;
			gcd_q    <= '0;
			status_q <= ST_OK;
		end else if (op == OP_FINISH) begin
			inv_q    <= inv_val;
			gcd_q    <= r0_q;
			status_q <= status_val;
		end
	end

	assign out_inverse = inv_q;
	assign out_gcd     = gcd_q;
	assign out_status  = status_q;

endmodule

FILE: sv/mie_ctrl.sv
// Controller: sequences Euclid steps and owns both handshakes.
module mie_ctrl
	import mie_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  dp_flags_t flags,
	output dp_op_t    op
);

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        load_out;

	// State register and output word valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and datapath operation.
	always_comb begin
		state_d  = state_q;
		op       = OP_NONE;
		in_ready = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op      = OP_LOAD;
					state_d = S_START;
				end
			end
			S_START: begin
				if (flags.r1_zero) begin
					state_d = S_FINISH;
				end else begin
					op      = OP_BEGIN;
					state_d = S_ALIGN;
				end
			end
			S_ALIGN: begin
				if (flags.aligned) begin
					state_d = S_REDUCE;
				end else begin
					op = OP_ALIGN;
				end
			end
			S_REDUCE: begin
				if (flags.cnt_zero) begin
					op      = OP_SWAP;
					state_d = S_START;
				end else begin
					op = OP_REDUCE;
				end
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					op       = OP_FINISH;
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

FILE: sv/modular_inverse_ext_euclid_unit.sv
// Top level: modular inverse by the extended Euclidean algorithm.
// A zero modulus goes straight from the load to the finish; otherwise each Euclid step
// aligns the divisor, reduces once per quotient bit and swaps the remainder and
// coefficient pairs. One word is in work at a time, bounded by the shift-subtract loop.
// A new word is accepted in the same cycle that the previous result first sits in the output register.
// Reset is asynchronous, active low, and clears the controller, output valid and result.
module modular_inverse_ext_euclid_unit
	import mie_pkg::*;
#(
	parameter int OPERAND_BITS = OPERAND_BITS_DEF,
	localparam int IN_BITS  = ((2 * OPERAND_BITS + 7) / 8) * 8,
	localparam int OUT_BITS = ((2 * OPERAND_BITS + STATUS_BITS + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// value, modulus (from bit 0 up), zero padded
	input  logic [IN_BITS-1:0]  s_axis_tdata,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// inverse, common_divisor, status (from bit 0 up), zero padded
	output logic [OUT_BITS-1:0] m_axis_tdata
);

	localparam int W = OPERAND_BITS;

	dp_op_t          op;
	dp_flags_t       flags;
	logic [W-1:0]    inverse, common_divisor;
	status_t         status;

	// Sequencer.
	mie_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.flags     (flags),
		.op        (op)
	);

	// Arithmetic.
	mie_datapath #(
		.OPERAND_BITS (OPERAND_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_value    (s_axis_tdata[W-1:0]),
		.in_modulus  (s_axis_tdata[2*W-1:W]),
		.op          (op),
		.flags       (flags),
		.out_inverse (inverse),
		.out_gcd     (common_divisor),
		.out_status  (status)
	);

	// Pack the result word.
	assign m_axis_tdata = OUT_BITS'({status, common_divisor, inverse});

endmodule
